// ===== src/hsot_pkg.sv =====
// ----------------------------------------------------------------------------
// hsot_pkg
// Shared constants and types for the hunt search over an ordered table.
// ----------------------------------------------------------------------------
package hsot_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // field widths of the request and result
    localparam int POS_W   = 7;
    localparam int INDEX_W = 6;
    // bracket arithmetic needs headroom for lo + 2 * step
    localparam int SPOS_W  = POS_W + 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // table length register reset value
    localparam logic [POS_W-1:0] LENGTH_RESET = POS_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_HUNT,
        CMD_BISECT
    } cmd_kind_t;

    // classified command; value is the entry for writes, the key for searches
    typedef struct packed {
        cmd_kind_t                      kind;
        logic [ADDR_W-1:0]              addr;
        logic signed [VALUE_WIDTH-1:0]  value;
        logic [POS_W-1:0]               guess;
        logic [POS_W-1:0]               n;
    } cmd_t;

endpackage

// ===== src/hsot_front.sv =====
// ----------------------------------------------------------------------------
// hsot_front
// Accepts requests, holds the length register and classifies each request
// into a table write, a hunt from a guess or a plain bisection.
// ----------------------------------------------------------------------------
module hsot_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hsot_pkg::POS_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_action,
    input  logic [hsot_pkg::INDEX_W-1:0]      in_index,
    input  logic signed [hsot_pkg::VALUE_WIDTH-1:0] in_entry,
    input  logic signed [hsot_pkg::VALUE_WIDTH-1:0] in_key,
    input  logic [hsot_pkg::POS_W-1:0]        in_guess,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output hsot_pkg::cmd_t                    cmd
);
    import hsot_pkg::*;

    logic [POS_W-1:0] len_reg;
    logic             vld_reg, vld_next;
    cmd_t             cmd_reg, cmd_next;
    logic [POS_W-1:0] n_eff;
    logic             guess_ok;
    logic             index_ok;
    logic             take;

    // length register, clamped to 1..depth when used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        priority if (len_reg == '0)
        begin
            n_eff = POS_W'(1);
        end
        else if (len_reg > POS_W'(TABLE_DEPTH))
        begin
            n_eff = POS_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = len_reg;
        end
    end

    // classify the incoming request
    assign guess_ok = (in_guess != '0) && (in_guess <= n_eff);
    assign index_ok = ({1'b0, in_index} < (INDEX_W + 1)'(TABLE_DEPTH));

    assign in_ready  = !vld_reg || cmd_ready;
    assign take      = in_valid && in_ready;
    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        vld_next = vld_reg;
        cmd_next = cmd_reg;
        if (vld_reg && cmd_ready)
        begin
            vld_next = 1'b0;
        end
        if (take)
        begin
            cmd_next.addr  = ADDR_W'(in_index);
            cmd_next.guess = in_guess;
            cmd_next.n     = n_eff;
            if (in_action == ACT_WRITE)
            begin
                cmd_next.kind  = CMD_WRITE;
                cmd_next.value = in_entry;
                // writes past the table are dropped here
                vld_next       = index_ok;
            end
            else
            begin
                cmd_next.kind  = guess_ok ? CMD_HUNT : CMD_BISECT;
                cmd_next.value = in_key;
                vld_next       = 1'b1;
            end
        end
    end

    // staging register in front of the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ===== src/hsot_queue.sv =====
// ----------------------------------------------------------------------------
// hsot_queue
// Short command queue that decouples request intake from the search engine.
// ----------------------------------------------------------------------------
module hsot_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  hsot_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output hsot_pkg::cmd_t pop_cmd
);
    import hsot_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// ===== src/hsot_back.sv =====
// ----------------------------------------------------------------------------
// hsot_back
// Table memory and search sequencer: order probe, hunt by doubling steps,
// bisection, and the result register.
// ----------------------------------------------------------------------------
module hsot_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  hsot_pkg::cmd_t               q_cmd,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [hsot_pkg::POS_W-1:0]   res_pos
);
    import hsot_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_FIRST,
        ST_GUESS,
        ST_UP,
        ST_DOWN,
        ST_BISECT
    } state_t;

    state_t state_reg, state_next;
    logic   out_vld_reg, out_vld_next;
    logic [POS_W-1:0] res_reg, res_next;

    // table memory, read data registered
    logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rdata_reg;
    logic                          mem_we;
    logic [ADDR_W-1:0]             rd_addr;

    // search datapath
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic signed [VALUE_WIDTH-1:0] last_reg, last_next;
    logic                          asc_reg, asc_next;
    logic                          hunt_reg, hunt_next;
    logic [POS_W-1:0]              n_reg, n_next;
    logic [POS_W-1:0]              guess_reg, guess_next;
    logic [POS_W-1:0]              p_reg, p_next;
    logic [SPOS_W-1:0]             lo_reg, lo_next;
    logic [SPOS_W-1:0]             hi_reg, hi_next;
    logic [SPOS_W-1:0]             inc_reg, inc_next;

    logic [SPOS_W-1:0] p_wide;
    logic [SPOS_W-1:0] n_wide;
    logic [SPOS_W-1:0] inc2;
    logic [SPOS_W-1:0] hi_step;
    logic [SPOS_W-1:0] mid;
    logic [SPOS_W-1:0] lo_c, hi_c;
    logic              settle;
    logic              finish;
    logic [POS_W-1:0]  fin_val;

    assign p_wide  = SPOS_W'(p_reg);
    assign n_wide  = SPOS_W'(n_reg);
    assign inc2    = {inc_reg[SPOS_W-2:0], 1'b0};
    assign hi_step = hi_reg + inc2;
    assign mid     = (lo_c + hi_c) >> 1;
    assign rd_addr = ADDR_W'(p_next - POS_W'(1));

    assign res_valid = out_vld_reg;
    assign res_pos   = res_reg;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        out_vld_next = out_vld_reg;
        res_next     = res_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        asc_next     = asc_reg;
        hunt_next    = hunt_reg;
        n_next       = n_reg;
        guess_next   = guess_reg;
        p_next       = p_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        inc_next     = inc_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        lo_c         = lo_reg;
        hi_c         = hi_reg;
        settle       = 1'b0;
        finish       = 1'b0;
        fin_val      = '0;

        if (out_vld_reg && res_ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == CMD_WRITE)
                    begin
                        q_pop  = 1'b1;
                        mem_we = 1'b1;
                    end
                    else if (!out_vld_reg)
                    begin
                        // a search starts only with the result slot free
                        q_pop      = 1'b1;
                        key_next   = q_cmd.value;
                        n_next     = q_cmd.n;
                        guess_next = q_cmd.guess;
                        hunt_next  = (q_cmd.kind == CMD_HUNT);
                        p_next     = q_cmd.n;
                        state_next = ST_LAST;
                    end
                end
            end
            ST_LAST:
            begin
                last_next  = rdata_reg;
                p_next     = POS_W'(1);
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                // ascending only when last entry is strictly above the first
                asc_next = (last_reg > rdata_reg);
                if (hunt_reg)
                begin
                    p_next     = guess_reg;
                    state_next = ST_GUESS;
                end
                else
                begin
                    lo_c   = '0;
                    hi_c   = n_wide + SPOS_W'(1);
                    settle = 1'b1;
                end
            end
            ST_GUESS:
            begin
                inc_next = SPOS_W'(1);
                if ((key_reg >= rdata_reg) == asc_reg)
                begin
                    if (guess_reg == n_reg)
                    begin
                        finish  = 1'b1;
                        fin_val = n_reg;
                    end
                    else
                    begin
                        lo_next    = SPOS_W'(guess_reg);
                        hi_next    = SPOS_W'(guess_reg) + SPOS_W'(1);
                        p_next     = guess_reg + POS_W'(1);
                        state_next = ST_UP;
                    end
                end
                else
                begin
                    if (guess_reg == POS_W'(1))
                    begin
                        finish  = 1'b1;
                        fin_val = '0;
                    end
                    else
                    begin
                        hi_next    = SPOS_W'(guess_reg);
                        lo_next    = SPOS_W'(guess_reg) - SPOS_W'(1);
                        p_next     = guess_reg - POS_W'(1);
                        state_next = ST_DOWN;
                    end
                end
            end
            ST_UP:
            begin
                // widen upward by doubling steps
                if ((key_reg >= rdata_reg) == asc_reg)
                begin
                    inc_next = inc2;
                    if (hi_step > n_wide)
                    begin
                        lo_c   = hi_reg;
                        hi_c   = n_wide + SPOS_W'(1);
                        settle = 1'b1;
                    end
                    else
                    begin
                        lo_next = hi_reg;
                        hi_next = hi_step;
                        p_next  = POS_W'(hi_step);
                    end
                end
                else
                begin
                    settle = 1'b1;
                end
            end
            ST_DOWN:
            begin
                // widen downward by doubling steps
                if ((key_reg < rdata_reg) == asc_reg)
                begin
                    inc_next = inc2;
                    if (inc2 >= lo_reg)
                    begin
                        lo_c   = '0;
                        hi_c   = lo_reg;
                        settle = 1'b1;
                    end
                    else
                    begin
                        hi_next = lo_reg;
                        lo_next = lo_reg - inc2;
                        p_next  = POS_W'(lo_reg - inc2);
                    end
                end
                else
                begin
                    settle = 1'b1;
                end
            end
            ST_BISECT:
            begin
                if ((key_reg > rdata_reg) == asc_reg)
                begin
                    lo_c = p_wide;
                end
                else
                begin
                    hi_c = p_wide;
                end
                settle = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // close the bracket or probe its midpoint
        if (settle)
        begin
            if ((hi_c - lo_c) == SPOS_W'(1))
            begin
                finish  = 1'b1;
                fin_val = POS_W'(lo_c);
            end
            else
            begin
                lo_next    = lo_c;
                hi_next    = hi_c;
                p_next     = POS_W'(mid);
                state_next = ST_BISECT;
            end
        end

        if (finish)
        begin
            out_vld_next = 1'b1;
            res_next     = fin_val;
            state_next   = ST_IDLE;
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            res_reg     <= res_next;
        end
    end

    // search datapath registers
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        last_reg  <= last_next;
        asc_reg   <= asc_next;
        hunt_reg  <= hunt_next;
        n_reg     <= n_next;
        guess_reg <= guess_next;
        p_reg     <= p_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        inc_reg   <= inc_next;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_cmd.addr] <= q_cmd.value;
        end
        rdata_reg <= mem[rd_addr];
    end

    a_probe_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GUESS || state_reg == ST_UP || state_reg == ST_DOWN ||
         state_reg == ST_BISECT) |-> (p_reg >= POS_W'(1)) && (p_reg <= n_reg))
        else $error("probe position outside the table");

    a_bisect_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BISECT) |-> (lo_reg < p_wide) && (p_wide < hi_reg))
        else $error("bisection probe outside its bracket");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (res_reg <= n_reg))
        else $error("bracket position beyond table length");

endmodule

// ===== src/hunt_search_ordered_table_top.sv =====
// ----------------------------------------------------------------------------
// hunt_search_ordered_table_top
// Bracketing hunt search over a loaded ordered table of signed Q16.16 values.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream. tuser bit 0 selects a table write (0) or
// a search (1). A write stores one entry and gives no result; a search gives
// one bracket position on the m_ stream. The table length register is to be
// set through cfg_we / cfg_wdata while the block is idle; the block does not
// enforce this. 0 acts as 1 and values above the depth act as the depth.
// Requests pass a staging register and a two-entry queue before the search
// engine, so intake goes on while a result waits for the receiver. A search
// probes the last and the first entry for the order; a hunt then probes the
// guess and widens by doubling steps; bisection steps then narrow the bracket,
// each step bound by one registered read of the table memory. A search waits
// at the queue head while the previous result is still held, so a stalled
// receiver lets the queue and the staging register fill, three requests in
// all, before s_tready drops. Reset empties the queue, drops any held result
// and sets the length to 64; table contents are not cleared and must be
// written before they are searched.
// ----------------------------------------------------------------------------
module hunt_search_ordered_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,   // table_length
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[5:0], entry_value[37:6], search_key[69:38],
    // start_guess[76:70], zero fill[79:77]
    input  logic [79:0] s_tdata,
    input  logic [0:0]  s_tuser,     // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata      // bracket_position[6:0], zero fill[7]
);
    import hsot_pkg::*;

    cmd_t             front_cmd;
    logic             front_valid;
    logic             front_ready;
    cmd_t             q_cmd;
    logic             q_valid;
    logic             q_pop;
    logic [POS_W-1:0] res_pos;

    // request intake and classification
    hsot_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser[0]),
        .in_index  (s_tdata[5:0]),
        .in_entry  (s_tdata[37:6]),
        .in_key    (s_tdata[69:38]),
        .in_guess  (s_tdata[76:70]),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // command queue
    hsot_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    // table memory and search engine
    hsot_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_pos   (res_pos)
    );

    assign m_tdata = {1'b0, res_pos};

endmodule
